// File: sv/ecd_pkg.sv
// ----------------------------------------------------------------------------
// ecd_pkg - shared types for the epoch-to-civil-date converter
// Holds the widths of the configuration field and the record handed from
// the time-splitting pipeline to the date pipeline.
// ----------------------------------------------------------------------------
package ecd_pkg;

    localparam int unsigned EPOCH_W  = 32;
    localparam int unsigned OFFSET_W = 5;
    localparam int unsigned DAYS_W   = 16;

    // Local time of day plus corrected day count, one record per transfer.
    typedef struct packed {
        logic [5:0]        sec;
        logic [5:0]        min;
        logic [4:0]        hour;
        logic [DAYS_W-1:0] days;     // days since 1970, plain-century fix applied
        logic              clamped;
    } ecd_time_t;

endpackage

// File: sv/ecd_time_split.sv
// ----------------------------------------------------------------------------
// ecd_time_split - seconds to hour/minute/second and day count
// Five register stages: split by 3600 via reciprocal, apply the zone offset
// in hours with clamp, then split minutes/seconds and hours/days.
// ----------------------------------------------------------------------------
module ecd_time_split (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic                                in_valid,
    input  logic [ecd_pkg::EPOCH_W-1:0]         epoch_seconds,
    input  logic signed [ecd_pkg::OFFSET_W-1:0] zone_offset,
    output logic                                out_valid,
    output ecd_pkg::ecd_time_t                  out_time
);

    // x/225 exact for x < 2**28
    localparam logic [28:0] RECIP_225 = 29'd305419897;
    // x/60 exact for x < 3600
    localparam logic [12:0] RECIP_60  = 13'd4370;
    // x/3 exact for x < 2**18
    localparam logic [18:0] RECIP_3   = 19'd349526;
    // first day index that lands after 2100-02-28
    localparam logic [15:0] CENTURY_SKIP_DAY = 16'(10957 + 36525 + 58 + 1);

    // valid pipe
    logic [4:0] valid_reg;
    logic [4:0] valid_next;

    // stage 1
    logic [56:0] s1_prod_reg, s1_prod_next;
    logic [27:0] s1_hi_reg;
    logic [3:0]  s1_lo_reg;
    logic signed [ecd_pkg::OFFSET_W-1:0] s1_off_reg;
    // stage 2
    logic [20:0] s2_hours_reg, s2_hours_next;
    logic [7:0]  s2_rem_reg, s2_rem_next;
    logic [3:0]  s2_lo_reg;
    logic signed [ecd_pkg::OFFSET_W-1:0] s2_off_reg;
    logic [27:0] s2_qx225;
    logic [27:0] s2_diff;
    // stage 3
    logic [11:0] s3_soh_reg, s3_soh_next;
    logic [20:0] s3_hours_reg, s3_hours_next;
    logic        s3_clamp_reg, s3_clamp_next;
    logic signed [21:0] s3_local;
    // stage 4
    logic [24:0] s4_pm_reg, s4_pm_next;
    logic [36:0] s4_pd_reg, s4_pd_next;
    logic [11:0] s4_soh_reg;
    logic [20:0] s4_hours_reg;
    logic        s4_clamp_reg;
    // stage 5
    ecd_pkg::ecd_time_t s5_time_reg, s5_time_next;
    logic [5:0]  s5_min;
    logic [15:0] s5_days;
    logic [11:0] s5_sec_full;
    logic [20:0] s5_hour_full;

    assign valid_next = {valid_reg[3:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        s1_prod_next = 57'(epoch_seconds[31:4]) * 57'(RECIP_225);

        s2_hours_next = s1_prod_reg[56:36];
        s2_qx225      = 28'(s2_hours_next) * 28'd225;
        s2_diff       = s1_hi_reg - s2_qx225;
        s2_rem_next   = s2_diff[7:0];

        // whole local hours; negative means before the epoch
        s3_local      = $signed({1'b0, s2_hours_reg}) + 22'(s2_off_reg);
        s3_clamp_next = s3_local[21];
        s3_hours_next = s3_clamp_next ? '0 : s3_local[20:0];
        s3_soh_next   = s3_clamp_next ? '0 : {s2_rem_reg, s2_lo_reg};

        s4_pm_next = 25'(s3_soh_reg) * 25'(RECIP_60);
        s4_pd_next = 37'(s3_hours_reg[20:3]) * 37'(RECIP_3);

        s5_min       = s4_pm_reg[23:18];
        s5_days      = s4_pd_reg[35:20];
        s5_sec_full  = s4_soh_reg - 12'(s5_min) * 12'd60;
        s5_hour_full = s4_hours_reg - 21'(s5_days) * 21'd24;

        s5_time_next.sec     = s5_sec_full[5:0];
        s5_time_next.min     = s5_min;
        s5_time_next.hour    = s5_hour_full[4:0];
        // days never reach 2200, so 2100 is the only plain century that needs the fix
        s5_time_next.days    = s5_days + 16'(s5_days >= CENTURY_SKIP_DAY);
        s5_time_next.clamped = s4_clamp_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_prod_reg  <= s1_prod_next;
            s1_hi_reg    <= epoch_seconds[31:4];
            s1_lo_reg    <= epoch_seconds[3:0];
            s1_off_reg   <= zone_offset;

            s2_hours_reg <= s2_hours_next;
            s2_rem_reg   <= s2_rem_next;
            s2_lo_reg    <= s1_lo_reg;
            s2_off_reg   <= s1_off_reg;

            s3_soh_reg   <= s3_soh_next;
            s3_hours_reg <= s3_hours_next;
            s3_clamp_reg <= s3_clamp_next;

            s4_pm_reg    <= s4_pm_next;
            s4_pd_reg    <= s4_pd_next;
            s4_soh_reg   <= s3_soh_reg;
            s4_hours_reg <= s3_hours_reg;
            s4_clamp_reg <= s3_clamp_reg;

            s5_time_reg  <= s5_time_next;
        end
    end

    assign out_valid = valid_reg[4];
    assign out_time  = s5_time_reg;

endmodule

// File: sv/ecd_date_calc.sv
// ----------------------------------------------------------------------------
// ecd_date_calc - day count to year, month and day
// Three register stages: reciprocal split into 4-year cycles, year within
// the cycle, then month and day lookup; the last stage is the output.
// ----------------------------------------------------------------------------
module ecd_date_calc (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               in_valid,
    input  ecd_pkg::ecd_time_t in_time,
    output logic               out_valid,
    output logic [5:0]         second_of_minute,
    output logic [5:0]         minute_of_hour,
    output logic [4:0]         hour_of_day,
    output logic [11:0]        calendar_year,
    output logic [3:0]         month_number,
    output logic [4:0]         day_of_month,
    output logic               clamped_flag
);

    // x/1461 exact for x < 2**16
    localparam logic [16:0] RECIP_1461 = 17'd91868;
    localparam logic [11:0] BASE_YEAR  = 12'd1970;

    // first day of month idx within the year
    function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
        logic [8:0] s;
        case (idx)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd59;
            4'd3:    s = 9'd90;
            4'd4:    s = 9'd120;
            4'd5:    s = 9'd151;
            4'd6:    s = 9'd181;
            4'd7:    s = 9'd212;
            4'd8:    s = 9'd243;
            4'd9:    s = 9'd273;
            4'd10:   s = 9'd304;
            4'd11:   s = 9'd334;
            default: s = 9'd0;
        endcase
        if (leap && (idx inside {[4'd2:4'd11]}))
        begin
            s = s + 9'd1;
        end
        return s;
    endfunction

    logic [2:0] valid_reg;
    logic [2:0] valid_next;

    // stage 6
    logic [32:0]        s6_prod_reg, s6_prod_next;
    ecd_pkg::ecd_time_t s6_time_reg;
    // stage 7
    logic [8:0]  s7_doy_reg, s7_doy_next;
    logic        s7_leap_reg, s7_leap_next;
    logic [11:0] s7_year_reg, s7_year_next;
    ecd_pkg::ecd_time_t s7_time_reg;
    logic [5:0]  s7_four;
    logic [15:0] s7_left_full;
    logic [10:0] s7_left;
    logic [1:0]  s7_y;
    logic [10:0] s7_doy_full;
    // stage 8
    logic [3:0]  s8_month_reg, s8_month_next;
    logic [4:0]  s8_day_reg, s8_day_next;
    logic [11:0] s8_year_reg;
    ecd_pkg::ecd_time_t s8_time_reg;
    logic [3:0]  s8_idx;
    logic [8:0]  s8_dom;

    assign valid_next = {valid_reg[1:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        s6_prod_next = 33'(in_time.days) * 33'(RECIP_1461);

        s7_four      = s6_prod_reg[32:27];
        s7_left_full = s6_time_reg.days - 16'(s7_four) * 16'd1461;
        s7_left      = s7_left_full[10:0];
        // cycle starts 1970: plain, plain, leap, plain
        if (s7_left < 11'd365)
        begin
            s7_y        = 2'd0;
            s7_doy_full = s7_left;
        end
        else if (s7_left < 11'd730)
        begin
            s7_y        = 2'd1;
            s7_doy_full = s7_left - 11'd365;
        end
        else if (s7_left < 11'd1096)
        begin
            s7_y        = 2'd2;
            s7_doy_full = s7_left - 11'd730;
        end
        else
        begin
            s7_y        = 2'd3;
            s7_doy_full = s7_left - 11'd1096;
        end
        s7_doy_next  = s7_doy_full[8:0];
        s7_leap_next = (s7_y == 2'd2);
        s7_year_next = BASE_YEAR + {4'd0, s7_four, 2'b00} + 12'(s7_y);

        // month index = number of later month starts already passed
        s8_idx = '0;
        for (int k = 1; k < 12; k++)
        begin
            s8_idx = s8_idx + 4'(s7_doy_reg >= month_start(4'(k), s7_leap_reg));
        end
        s8_dom        = s7_doy_reg - month_start(s8_idx, s7_leap_reg) + 9'd1;
        s8_month_next = s8_idx + 4'd1;
        s8_day_next   = s8_dom[4:0];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s6_prod_reg  <= s6_prod_next;
            s6_time_reg  <= in_time;

            s7_doy_reg   <= s7_doy_next;
            s7_leap_reg  <= s7_leap_next;
            s7_year_reg  <= s7_year_next;
            s7_time_reg  <= s6_time_reg;

            s8_month_reg <= s8_month_next;
            s8_day_reg   <= s8_day_next;
            s8_year_reg  <= s7_year_reg;
            s8_time_reg  <= s7_time_reg;
        end
    end

    assign out_valid        = valid_reg[2];
    assign second_of_minute = s8_time_reg.sec;
    assign minute_of_hour   = s8_time_reg.min;
    assign hour_of_day      = s8_time_reg.hour;
    assign calendar_year    = s8_year_reg;
    assign month_number     = s8_month_reg;
    assign day_of_month     = s8_day_reg;
    assign clamped_flag     = s8_time_reg.clamped;

endmodule

// File: sv/epoch_seconds_to_civil_date.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_civil_date - Unix seconds to local Gregorian date and time
// Adds a whole-hour zone offset to a 32-bit seconds count and returns
// second, minute, hour, year, month, day and a clamp flag.
// ----------------------------------------------------------------------------
// Usage
//   Input channel : in_valid / in_ready, payload epoch_seconds (unsigned).
//   Output channel: out_valid / out_ready, one result per input transfer,
//                   results leave in input order.
//   Config        : cfg_wr_en / cfg_wr_data load the signed zone offset in
//                   hours; write only while the pipe is empty. Reset value +8.
//   Throughput    : one transfer per cycle unless stalled; eight register
//                   stages, each with at most two constant-reciprocal multiplies.
//   Reset         : rst_n clears all stage valids and reloads offset +8.
//   Stall         : while out_valid is high and out_ready low the whole pipe
//                   freezes and in_ready drops; nothing is lost or repeated.
//   Before epoch  : a local time below zero reads as 1970-01-01 00:00:00
//                   with clamped_flag set.
// ----------------------------------------------------------------------------
module epoch_seconds_to_civil_date (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic signed [ecd_pkg::OFFSET_W-1:0] cfg_wr_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ecd_pkg::EPOCH_W-1:0]         epoch_seconds,
    // output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [5:0]                          second_of_minute,
    output logic [5:0]                          minute_of_hour,
    output logic [4:0]                          hour_of_day,
    output logic [11:0]                         calendar_year,
    output logic [3:0]                          month_number,
    output logic [4:0]                          day_of_month,
    output logic                                clamped_flag
);

    localparam logic signed [ecd_pkg::OFFSET_W-1:0] OFFSET_RESET = 5'sd8;

    logic signed [ecd_pkg::OFFSET_W-1:0] zone_offset_reg;
    logic signed [ecd_pkg::OFFSET_W-1:0] zone_offset_next;

    logic               advance;
    logic               mid_valid;
    ecd_pkg::ecd_time_t mid_time;

    // Global stall: the pipe moves whenever the final stage is free or drains.
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    assign zone_offset_next = cfg_wr_en ? cfg_wr_data : zone_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_offset_reg <= OFFSET_RESET;
        end
        else
        begin
            zone_offset_reg <= zone_offset_next;
        end
    end

    // Stages 1-5: split seconds, apply offset and clamp, derive day count.
    ecd_time_split u_time_split (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_valid      (in_valid),
        .epoch_seconds (epoch_seconds),
        .zone_offset   (zone_offset_reg),
        .out_valid     (mid_valid),
        .out_time      (mid_time)
    );

    // Stages 6-8: 4-year cycle, year in cycle, month and day; stage 8 is
    // the output register.
    ecd_date_calc u_date_calc (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .in_valid         (mid_valid),
        .in_time          (mid_time),
        .out_valid        (out_valid),
        .second_of_minute (second_of_minute),
        .minute_of_hour   (minute_of_hour),
        .hour_of_day      (hour_of_day),
        .calendar_year    (calendar_year),
        .month_number     (month_number),
        .day_of_month     (day_of_month),
        .clamped_flag     (clamped_flag)
    );

endmodule
